@@ rtl/lip_pkg.sv @@
// line intersection package: widths, register indexes, division cell types
// used by all modules of the block but the checker; depends on nothing
package lip_pkg;

  localparam int unsigned CoordWidth = 16;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  localparam int unsigned DetWidth   = ProdWidth + 1;
  // magnitude of a numerator shifted up by the fraction bits
  localparam int unsigned NumWidth   = DetWidth + FracBits;
  localparam int unsigned QuotWidth  = NumWidth;
  localparam int unsigned ResWidth   = 32;
  localparam int unsigned AddrWidth  = 5;

  typedef enum logic [AddrWidth-1:0] {
    RegSegStartX = 5'd0,
    RegSegStartY = 5'd4,
    RegSegEndX   = 5'd8,
    RegSegEndY   = 5'd12,
    RegMinDet    = 5'd16
  } reg_addr_e;

  // one division in flight through the cell row
  typedef struct packed {
    logic [NumWidth-1:0]  num;
    logic [DetWidth-1:0]  rem;
    logic [QuotWidth-1:0] quo;
    logic                 neg;
  } div_lane_t;

  // request traveling alongside the division lanes
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [DetWidth-1:0] den;
  } lip_ctrl_t;

endpackage

@@ rtl/lip_front.sv @@
// front stage: differences, cross products, determinant and threshold test
// depends on lip_pkg
module lip_front (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   sx_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   sy_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   ex_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   ey_i,
  input  logic        [31:0]                      min_det_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   ox_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   oy_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   qx_i,
  input  logic signed [lip_pkg::CoordWidth-1:0]   qy_i,
  input  logic                                     valid_i,
  output lip_pkg::lip_ctrl_t                       ctrl_o,
  output lip_pkg::div_lane_t                       lane_s_o,
  output lip_pkg::div_lane_t                       lane_o_o
);
  import lip_pkg::*;

  logic signed [DiffWidth-1:0] a_q, d_q, b_q, e_q, c_q, f_q;
  logic signed [ProdWidth-1:0] ea_q, bd_q, ce_q, bf_q, af_q, cd_q;
  logic [31:0] thr_q, thr2_q;
  logic        v1_q, v2_q;
  logic signed [DetWidth-1:0] det, ns, no;
  logic [DetWidth-1:0] adet, ans, ano;
  logic hit;

  // stage 1: differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= DiffWidth'(ex_i) - DiffWidth'(sx_i);
      d_q   <= DiffWidth'(ey_i) - DiffWidth'(sy_i);
      b_q   <= DiffWidth'(ox_i) - DiffWidth'(qx_i);
      e_q   <= DiffWidth'(oy_i) - DiffWidth'(qy_i);
      c_q   <= DiffWidth'(ox_i) - DiffWidth'(sx_i);
      f_q   <= DiffWidth'(oy_i) - DiffWidth'(sy_i);
      thr_q <= min_det_i;
      v1_q  <= valid_i;
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ea_q   <= e_q * a_q;
      bd_q   <= b_q * d_q;
      ce_q   <= c_q * e_q;
      bf_q   <= b_q * f_q;
      af_q   <= a_q * f_q;
      cd_q   <= c_q * d_q;
      thr2_q <= thr_q;
      v2_q   <= v1_q;
    end
  end

  // determinant, numerators and threshold
  always_comb begin
    det  = DetWidth'(ea_q) - DetWidth'(bd_q);
    ns   = DetWidth'(ce_q) - DetWidth'(bf_q);
    no   = DetWidth'(af_q) - DetWidth'(cd_q);
    adet = det[DetWidth-1] ? DetWidth'(-det) : DetWidth'(det);
    ans  = ns[DetWidth-1] ? DetWidth'(-ns) : DetWidth'(ns);
    ano  = no[DetWidth-1] ? DetWidth'(-no) : DetWidth'(no);
    hit  = (adet != '0) && (adet >= DetWidth'(thr2_q));
  end

  // stage 3: launch into the divider row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o.valid   <= v2_q;
      ctrl_o.hit     <= hit;
      ctrl_o.den     <= adet;
      lane_s_o.num   <= {ans, FracBits'(0)};
      lane_s_o.rem   <= '0;
      lane_s_o.quo   <= '0;
      lane_s_o.neg   <= ns[DetWidth-1] ^ det[DetWidth-1];
      lane_o_o.num   <= {ano, FracBits'(0)};
      lane_o_o.rem   <= '0;
      lane_o_o.quo   <= '0;
      lane_o_o.neg   <= no[DetWidth-1] ^ det[DetWidth-1];
    end
  end

endmodule

@@ rtl/lip_div_cell.sv @@
// one restoring-division cell: one quotient bit for each of two lanes
// depends on lip_pkg
module lip_div_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  lip_pkg::lip_ctrl_t ctrl_i,
  input  lip_pkg::div_lane_t lane_s_i,
  input  lip_pkg::div_lane_t lane_o_i,
  output lip_pkg::lip_ctrl_t ctrl_o,
  output lip_pkg::div_lane_t lane_s_o,
  output lip_pkg::div_lane_t lane_o_o
);
  import lip_pkg::*;

  function automatic div_lane_t step(div_lane_t l, logic [DetWidth-1:0] den);
    logic [DetWidth:0] r;
    div_lane_t o;
    r = {l.rem, l.num[NumWidth-1]};
    o = l;
    o.num = {l.num[NumWidth-2:0], 1'b0};
    if (r >= {1'b0, den}) begin
      r = r - {1'b0, den};
      o.quo = {l.quo[QuotWidth-2:0], 1'b1};
    end else begin
      o.quo = {l.quo[QuotWidth-2:0], 1'b0};
    end
    o.rem = r[DetWidth-1:0];
    return o;
  endfunction

  // shift, compare, subtract and hand on
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o   <= ctrl_i;
      lane_s_o <= step(lane_s_i, ctrl_i.den);
      lane_o_o <= step(lane_o_i, ctrl_i.den);
    end
  end

endmodule

@@ rtl/lip_back.sv @@
// final stage: sign, saturation and zeroing of no-hit results
// depends on lip_pkg
module lip_back (
  input  lip_pkg::lip_ctrl_t                ctrl_i,
  input  lip_pkg::div_lane_t                lane_s_i,
  input  lip_pkg::div_lane_t                lane_o_i,
  output logic [2*lip_pkg::ResWidth+1:0]    res_o
);
  import lip_pkg::*;

  function automatic logic [ResWidth:0] fix(div_lane_t l);
    logic [QuotWidth-1:0] lim;
    logic [QuotWidth-1:0] mag;
    logic sat;
    lim = l.neg ? QuotWidth'(64'h8000_0000) : QuotWidth'(64'h7FFF_FFFF);
    sat = l.quo > lim;
    mag = sat ? lim : l.quo;
    mag = l.neg ? QuotWidth'(-mag) : mag;
    return {sat, mag[ResWidth-1:0]};
  endfunction

  logic [ResWidth:0] rs, ro;

  // fields: hit, t_self, t_other, saturated from bit 0 up
  always_comb begin
    rs = fix(lane_s_i);
    ro = fix(lane_o_i);
    if (ctrl_i.hit) begin
      res_o = {rs[ResWidth] | ro[ResWidth], ro[ResWidth-1:0], rs[ResWidth-1:0], 1'b1};
    end else begin
      res_o = '0;
    end
  end

endmodule

@@ rtl/line_intersection_params.sv @@
// top level of the line intersection block: config port, pipeline, output register
// depends on lip_pkg, lip_front, lip_div_cell, lip_back
//
// Use: write the reference segment and min_det over the APB port while idle,
// then stream segments on s_axis (tdata: other_start_x, other_start_y,
// other_end_x, other_end_y, 16 bits each from bit 0 up). Each request gives
// one result on m_axis (tdata: hit, t_self, t_other, saturated from bit 0,
// zero filled to 72 bits). A request passes 3 front stages, one division
// cell per quotient bit (NumWidth = 51 cells) and the output register.
// Throughput is one request per cycle while the row advances: every cell
// holds one request. The row advances as a whole while the output register
// is empty or being taken; when the receiver stalls with a result waiting,
// the whole row freezes and s_axis_tready falls. Reset clears the valid
// bits in the row and the output, sets the coordinates to 0 and min_det to 1.
module line_intersection_params (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // other_start_x, other_start_y, other_end_x, other_end_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // hit, t_self, t_other, saturated
);
  import lip_pkg::*;

  localparam int unsigned Cells = NumWidth;
  localparam int unsigned ResBits = 2 * ResWidth + 2;

  logic [CoordWidth-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [31:0] min_det_q;
  logic en;
  logic out_v_q;
  logic [ResBits-1:0] out_q, res;

  lip_ctrl_t ctrl   [Cells+1];
  div_lane_t lane_s [Cells+1];
  div_lane_t lane_o [Cells+1];

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
      min_det_q <= 32'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegSegStartX: sx_q <= pwdata[CoordWidth-1:0];
        RegSegStartY: sy_q <= pwdata[CoordWidth-1:0];
        RegSegEndX:   ex_q <= pwdata[CoordWidth-1:0];
        RegSegEndY:   ey_q <= pwdata[CoordWidth-1:0];
        RegMinDet:    min_det_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr)
      RegSegStartX: prdata = {{(32-CoordWidth){sx_q[CoordWidth-1]}}, sx_q};
      RegSegStartY: prdata = {{(32-CoordWidth){sy_q[CoordWidth-1]}}, sy_q};
      RegSegEndX:   prdata = {{(32-CoordWidth){ex_q[CoordWidth-1]}}, ex_q};
      RegSegEndY:   prdata = {{(32-CoordWidth){ey_q[CoordWidth-1]}}, ey_q};
      RegMinDet:    prdata = min_det_q;
      default:      prdata = '0;
    endcase
  end

  // row advances unless a waiting result is stalled
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  lip_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .sx_i     (sx_q),
    .sy_i     (sy_q),
    .ex_i     (ex_q),
    .ey_i     (ey_q),
    .min_det_i(min_det_q),
    .ox_i     (s_axis_tdata[15:0]),
    .oy_i     (s_axis_tdata[31:16]),
    .qx_i     (s_axis_tdata[47:32]),
    .qy_i     (s_axis_tdata[63:48]),
    .valid_i  (s_axis_tvalid),
    .ctrl_o   (ctrl[0]),
    .lane_s_o (lane_s[0]),
    .lane_o_o (lane_o[0])
  );

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    lip_div_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (en),
      .ctrl_i  (ctrl[g]),
      .lane_s_i(lane_s[g]),
      .lane_o_i(lane_o[g]),
      .ctrl_o  (ctrl[g+1]),
      .lane_s_o(lane_s[g+1]),
      .lane_o_o(lane_o[g+1])
    );
  end

  lip_back u_back (
    .ctrl_i  (ctrl[Cells]),
    .lane_s_i(lane_s[Cells]),
    .lane_o_i(lane_o[Cells]),
    .res_o   (res)
  );

  // valid bits of the row: the payload registers carry no reset,
  // so the valid flag travels in a reset shift line alongside
  logic [Cells+2:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Cells+1:0], s_axis_tvalid};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld_q[Cells+2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(72-ResBits){1'b0}}, out_q};

endmodule

@@ rtl/lip_checker.sv @@
// port-level checker for the line intersection block, bound to the top level
// depends on nothing but the top level's ports
module lip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // no hit means all other fields are zero
  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[71:1] == '0)
    else $error("no-hit result carries data");

  // input side stalls exactly when a waiting result is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready out of step with output");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result after reset");

endmodule

bind line_intersection_params lip_checker u_lip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
